// File: hw/rtl/clock_setup_search_core_defines.svh
// Assertion macros used by the RTL file of the clock setup search core.
`ifndef CLOCK_SETUP_SEARCH_CORE_DEFINES_SVH
`define CLOCK_SETUP_SEARCH_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CSS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("clock setup search: assertion failed");
`define CSS_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("clock setup search: reset assertion failed");
`else
`define CSS_ASSERT(lbl, clk, rst, prop)
`define CSS_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// File: hw/rtl/css_pkg.sv
package css_pkg;

  localparam logic [31:0] MAX_MASTER_HZ  = 32'd120000000;
  localparam logic [32:0] PLL_OUT_MAX_HZ = 33'd240000000;
  localparam logic [6:0]  MAX_PLL_MUL    = 7'd80;
  localparam logic [25:0] RC_BASE_HZ     = 26'd12000000;
  localparam logic [31:0] RC4_HZ         = 32'd4000000;
  localparam logic [31:0] RC8_HZ         = 32'd8000000;
  localparam logic [31:0] RC12_HZ        = 32'd12000000;
  localparam logic [31:0] SLOW_CLOCK_HZ  = 32'd32768;
  localparam logic [2:0]  MAX_SHIFT      = 3'd6;

  typedef enum logic [2:0] {
    KIND_INVALID  = 3'd0,
    KIND_RC4      = 3'd1,
    KIND_RC8      = 3'd2,
    KIND_RC12     = 3'd3,
    KIND_SLOW     = 3'd4,
    KIND_XTAL     = 3'd5,
    KIND_XTAL_PLL = 3'd6,
    KIND_RC_PLL   = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_MUL,
    OP_DECMUL,
    OP_SETMAX,
    OP_INCSHIFT,
    OP_DECSHIFT,
    OP_SAVEACT,
    OP_MULUP,
    OP_PICK,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_SPECIAL,
    C_NOT_OVER_PLL,
    C_NOT_SHIFT_MORE,
    C_NOT_MUL_MORE,
    C_NOT_UP_OK,
    C_HOLD
  } cond_t;

  typedef struct packed {
    op_t        op;
    cond_t      cond;
    logic [3:0] target;
  } ctrl_t;

  localparam logic [3:0] STEP_START    = 4'd0;
  localparam logic [3:0] STEP_MAXMUL   = 4'd1;
  localparam logic [3:0] STEP_MAXTEST  = 4'd2;
  localparam logic [3:0] STEP_MAXDEC   = 4'd3;
  localparam logic [3:0] STEP_SETMAX   = 4'd4;
  localparam logic [3:0] STEP_SHTEST   = 4'd5;
  localparam logic [3:0] STEP_SHINC    = 4'd6;
  localparam logic [3:0] STEP_SHBACK   = 4'd7;
  localparam logic [3:0] STEP_MULTEST  = 4'd8;
  localparam logic [3:0] STEP_MULDEC   = 4'd9;
  localparam logic [3:0] STEP_MULPROD  = 4'd10;
  localparam logic [3:0] STEP_SAVEACT  = 4'd11;
  localparam logic [3:0] STEP_MULUP    = 4'd12;
  localparam logic [3:0] STEP_PICK     = 4'd13;
  localparam logic [3:0] STEP_FINISH   = 4'd14;

  function automatic ctrl_t rom_word(input logic [3:0] pc);
    ctrl_t w;
    w = '{op: OP_NOP, cond: C_NEVER, target: STEP_START};
    unique case (pc)
      STEP_START:   w = '{op: OP_INIT,     cond: C_SPECIAL,        target: STEP_FINISH};
      STEP_MAXMUL:  w = '{op: OP_MUL,      cond: C_NEVER,          target: STEP_START};
      STEP_MAXTEST: w = '{op: OP_NOP,      cond: C_NOT_OVER_PLL,   target: STEP_SETMAX};
      STEP_MAXDEC:  w = '{op: OP_DECMUL,   cond: C_ALWAYS,         target: STEP_MAXMUL};
      STEP_SETMAX:  w = '{op: OP_SETMAX,   cond: C_NEVER,          target: STEP_START};
      STEP_SHTEST:  w = '{op: OP_NOP,      cond: C_NOT_SHIFT_MORE, target: STEP_SHBACK};
      STEP_SHINC:   w = '{op: OP_INCSHIFT, cond: C_ALWAYS,         target: STEP_SHTEST};
      STEP_SHBACK:  w = '{op: OP_DECSHIFT, cond: C_NEVER,          target: STEP_START};
      STEP_MULTEST: w = '{op: OP_NOP,      cond: C_NOT_MUL_MORE,   target: STEP_SAVEACT};
      STEP_MULDEC:  w = '{op: OP_DECMUL,   cond: C_NEVER,          target: STEP_START};
      STEP_MULPROD: w = '{op: OP_MUL,      cond: C_ALWAYS,         target: STEP_MULTEST};
      STEP_SAVEACT: w = '{op: OP_SAVEACT,  cond: C_NOT_UP_OK,      target: STEP_FINISH};
      STEP_MULUP:   w = '{op: OP_MULUP,    cond: C_NEVER,          target: STEP_START};
      STEP_PICK:    w = '{op: OP_PICK,     cond: C_NEVER,          target: STEP_START};
      STEP_FINISH:  w = '{op: OP_FINISH,   cond: C_HOLD,           target: STEP_FINISH};
      default:      w = '{op: OP_NOP,      cond: C_ALWAYS,         target: STEP_START};
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/clock_setup_search_core.sv
// Picks a master clock setup for a requested frequency: RC oscillator, slow clock, crystal,
// or a PLL from the crystal (or the 12 MHz RC when no crystal is given) followed by a
// power-of-two prescaler. A small microprogram drives one 7 by 26 bit multiplier whose
// product is registered, so each test reads a product stored by an earlier step. Requests
// that need no PLL go straight from the start step to the finish step. A PLL request lowers
// the multiplier from 80 to M, the largest that keeps the PLL at or below 240 MHz, raises
// the prescaler while the output is above the target, steps it back by one, lowers the
// multiplier to m where the search stops, and takes m + 1 if m < M and it is strictly nearer.
// One request is worked on at a time; the next is taken while a result waits at the output.
`include "clock_setup_search_core_defines.svh"

module clock_setup_search_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] target_hz,
  input  logic [25:0] xtal_hz,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  setup_kind,
  output logic [6:0]  pll_mul,
  output logic [2:0]  prescaler_code,
  output logic [27:0] master_hz
);

  logic                busy;
  logic                busy_next;
  logic [3:0]          pc;
  logic [3:0]          pc_next;
  logic                out_valid_next;
  css_pkg::ctrl_t      word;

  logic [31:0]         desired;
  logic [25:0]         crystal;
  logic [25:0]         base;
  logic [6:0]          mul;
  logic [6:0]          mul_max;
  logic [2:0]          shift;
  logic [32:0]         prod;
  logic [27:0]         actual;
  css_pkg::kind_t      kind;

  css_pkg::kind_t      kind_calc;
  logic                special;
  logic                accept;
  logic                hold;
  logic                publish;
  logic                cond_true;
  logic [6:0]          mul_sel;
  logic [32:0]         prod_calc;
  logic [32:0]         shifted;
  logic                above;
  logic [32:0]         dist_up;
  logic [32:0]         dist_act;
  logic                pll_kind;

  assign word     = css_pkg::rom_word(pc);
  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign hold     = out_valid && out_stall;
  assign publish  = busy && (word.op == css_pkg::OP_FINISH) && !hold;
  assign pll_kind = (kind == css_pkg::KIND_XTAL_PLL) || (kind == css_pkg::KIND_RC_PLL);

  always_comb begin
    kind_calc = css_pkg::KIND_RC_PLL;
    special   = 1'b1;
    if ((desired == 32'd0) || (desired > css_pkg::MAX_MASTER_HZ)) begin
      kind_calc = css_pkg::KIND_INVALID;
    end else if (desired == css_pkg::RC4_HZ) begin
      kind_calc = css_pkg::KIND_RC4;
    end else if (desired == css_pkg::RC8_HZ) begin
      kind_calc = css_pkg::KIND_RC8;
    end else if (desired == css_pkg::RC12_HZ) begin
      kind_calc = css_pkg::KIND_RC12;
    end else if (desired == css_pkg::SLOW_CLOCK_HZ) begin
      kind_calc = css_pkg::KIND_SLOW;
    end else if (crystal != 26'd0) begin
      if (desired == {6'd0, crystal}) begin
        kind_calc = css_pkg::KIND_XTAL;
      end else begin
        kind_calc = css_pkg::KIND_XTAL_PLL;
        special   = 1'b0;
      end
    end else begin
      kind_calc = css_pkg::KIND_RC_PLL;
      special   = 1'b0;
    end
  end

  assign mul_sel   = (word.op == css_pkg::OP_MULUP) ? mul + 7'd1 : mul;
  assign prod_calc = {26'd0, mul_sel} * {7'd0, base};
  assign shifted   = prod >> shift;
  assign above     = shifted > {1'b0, desired};
  assign dist_up   = (shifted > {1'b0, desired}) ? shifted - {1'b0, desired}
                                                 : {1'b0, desired} - shifted;
  assign dist_act  = ({5'd0, actual} > {1'b0, desired}) ? {5'd0, actual} - {1'b0, desired}
                                                        : {1'b0, desired} - {5'd0, actual};

  always_comb begin
    case (word.cond)
      css_pkg::C_NEVER:          cond_true = 1'b0;
      css_pkg::C_ALWAYS:         cond_true = 1'b1;
      css_pkg::C_SPECIAL:        cond_true = special;
      css_pkg::C_NOT_OVER_PLL:   cond_true = !((prod > css_pkg::PLL_OUT_MAX_HZ) &&
                                               (mul > 7'd1));
      css_pkg::C_NOT_SHIFT_MORE: cond_true = !(above && (shift < css_pkg::MAX_SHIFT));
      css_pkg::C_NOT_MUL_MORE:   cond_true = !(above && (mul > 7'd1));
      css_pkg::C_NOT_UP_OK:      cond_true = !(mul < mul_max);
      css_pkg::C_HOLD:           cond_true = hold;
      default:                   cond_true = 1'b0;
    endcase
  end

  always_comb begin
    busy_next      = busy;
    pc_next        = pc;
    out_valid_next = out_valid && out_stall;
    if (!busy) begin
      pc_next = css_pkg::STEP_START;
      if (accept) begin
        busy_next = 1'b1;
      end
    end else if (publish) begin
      busy_next      = 1'b0;
      pc_next        = css_pkg::STEP_START;
      out_valid_next = 1'b1;
    end else if (cond_true) begin
      pc_next = word.target;
    end else begin
      pc_next = pc + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= css_pkg::STEP_START;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      pc        <= pc_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desired <= target_hz;
      crystal <= xtal_hz;
    end
    if (busy) begin
      unique case (word.op)
        css_pkg::OP_INIT: begin
          kind  <= kind_calc;
          mul   <= css_pkg::MAX_PLL_MUL;
          shift <= 3'd0;
          base  <= (crystal != 26'd0) ? crystal : css_pkg::RC_BASE_HZ;
          actual <= (special && (kind_calc != css_pkg::KIND_INVALID)) ? desired[27:0]
                                                                      : 28'd0;
        end
        css_pkg::OP_MUL, css_pkg::OP_MULUP: begin
          prod <= prod_calc;
        end
        css_pkg::OP_DECMUL: begin
          mul <= mul - 7'd1;
        end
        css_pkg::OP_SETMAX: begin
          mul_max <= mul;
        end
        css_pkg::OP_INCSHIFT: begin
          shift <= shift + 3'd1;
        end
        css_pkg::OP_DECSHIFT: begin
          if (shift != 3'd0) begin
            shift <= shift - 3'd1;
          end
        end
        css_pkg::OP_SAVEACT: begin
          actual <= shifted[27:0];
        end
        css_pkg::OP_PICK: begin
          if (dist_up < dist_act) begin
            mul    <= mul + 7'd1;
            actual <= shifted[27:0];
          end
        end
        css_pkg::OP_NOP, css_pkg::OP_FINISH: begin
        end
        default: begin
        end
      endcase
    end
    if (publish) begin
      setup_kind     <= kind;
      pll_mul        <= pll_kind ? mul : 7'd0;
      prescaler_code <= pll_kind ? shift : 3'd0;
      master_hz      <= actual;
    end
  end

  `CSS_ASSERT_NORST(a_reset_idle, clk, rst |=> (!busy && !out_valid))
  `CSS_ASSERT(a_idle_at_start, clk, rst, !busy |-> (pc == css_pkg::STEP_START))
  `CSS_ASSERT(a_shift_range, clk, rst, (busy && (pc != css_pkg::STEP_START)) |-> (shift <= css_pkg::MAX_SHIFT))
  `CSS_ASSERT(a_mul_nonzero, clk, rst, (busy && (pc != css_pkg::STEP_START)) |-> (mul != 7'd0))
  `CSS_ASSERT(a_mul_bounded, clk, rst, (pll_kind && (pc > css_pkg::STEP_SETMAX)) |-> (mul <= mul_max))
  `CSS_ASSERT(a_publish_frees, clk, rst, publish |=> (!busy && out_valid))

endmodule

// File: test/clock_setup_search_core_checker.sv
`timescale 1ns / 1ps

module clock_setup_search_core_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] target_hz,
  input  logic [25:0] xtal_hz,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  setup_kind,
  input  logic [6:0]  pll_mul,
  input  logic [2:0]  prescaler_code,
  input  logic [27:0] master_hz,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    css_pkg::kind_t kind;
    logic [6:0]     mul;
    logic [2:0]     shift;
    logic [27:0]    freq;
  } clock_setup_t;

  clock_setup_t expected_setups[$];
  int           mismatches;

  function automatic longint unsigned distance(input longint unsigned a,
                                               input longint unsigned b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic clock_setup_t predict_setup(input logic [31:0] want,
                                                 input logic [25:0] xtal);
    clock_setup_t     s;
    longint unsigned  base;
    longint unsigned  top_mul;
    longint unsigned  m;
    longint unsigned  sh;
    longint unsigned  f;
    longint unsigned  up;
    s.kind  = css_pkg::KIND_INVALID;
    s.mul   = '0;
    s.shift = '0;
    s.freq  = '0;
    if (want == 32'd0 || want > css_pkg::MAX_MASTER_HZ) begin
      return s;
    end
    s.freq = want[27:0];
    if (want == css_pkg::RC4_HZ) begin
      s.kind = css_pkg::KIND_RC4;
    end else if (want == css_pkg::RC8_HZ) begin
      s.kind = css_pkg::KIND_RC8;
    end else if (want == css_pkg::RC12_HZ) begin
      s.kind = css_pkg::KIND_RC12;
    end else if (want == css_pkg::SLOW_CLOCK_HZ) begin
      s.kind = css_pkg::KIND_SLOW;
    end else if (xtal != 26'd0 && want == {6'd0, xtal}) begin
      s.kind = css_pkg::KIND_XTAL;
    end else begin
      s.kind = (xtal != 26'd0) ? css_pkg::KIND_XTAL_PLL : css_pkg::KIND_RC_PLL;
      base = (xtal != 26'd0) ? xtal : css_pkg::RC_BASE_HZ;
      top_mul = css_pkg::PLL_OUT_MAX_HZ / base;
      if (top_mul > css_pkg::MAX_PLL_MUL) top_mul = css_pkg::MAX_PLL_MUL;
      if (top_mul == 0) top_mul = 1;
      m = top_mul;
      sh = 0;
      while (((m * base) >> sh) > want && sh < css_pkg::MAX_SHIFT) sh++;
      if (sh > 0) sh--;
      while (((m * base) >> sh) > want && m > 1) m--;
      f = (m * base) >> sh;
      if (m < top_mul) begin
        up = ((m + 1) * base) >> sh;
        if (distance(up, want) < distance(want, f)) begin
          m++;
          f = up;
        end
      end
      s.mul   = m[6:0];
      s.shift = sh[2:0];
      s.freq  = f[27:0];
    end
    return s;
  endfunction

  always @(posedge clk) begin
    clock_setup_t exp_setup;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_setups.push_back(predict_setup(target_hz, xtal_hz));
      end
      if (out_valid && !out_stall) begin
        if (expected_setups.size() == 0) begin
          $error("result with no request waiting: setup_kind %0d, master_hz %0d",
                 setup_kind, master_hz);
          mismatches++;
        end else begin
          exp_setup = expected_setups.pop_front();
          if (setup_kind !== exp_setup.kind) begin
            $error("setup_kind: expected %0d, got %0d", exp_setup.kind, setup_kind);
            mismatches++;
          end
          if (pll_mul !== exp_setup.mul) begin
            $error("pll_mul: expected %0d, got %0d", exp_setup.mul, pll_mul);
            mismatches++;
          end
          if (prescaler_code !== exp_setup.shift) begin
            $error("prescaler_code: expected %0d, got %0d", exp_setup.shift, prescaler_code);
            mismatches++;
          end
          if (master_hz !== exp_setup.freq) begin
            $error("master_hz: expected %0d, got %0d", exp_setup.freq, master_hz);
            mismatches++;
          end
        end
      end
    end
    errors  <= mismatches;
    pending <= expected_setups.size();
  end

endmodule

// File: test/clock_setup_search_core_tb.sv
`timescale 1ns / 1ps

module clock_setup_search_core_tb;

  localparam int RANDOM_REQUESTS = 1880;
  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int TAIL_CYCLES     = 300;
  localparam int MAX_CRYSTAL_HZ  = 50000000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] target_hz;
  logic [25:0] xtal_hz;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  setup_kind;
  logic [6:0]  pll_mul;
  logic [2:0]  prescaler_code;
  logic [27:0] master_hz;

  int errors;
  int pending;
  int idle_cycles;
  int calm_left;
  bit drain_hung;

  clock_setup_search_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .target_hz      (target_hz),
    .xtal_hz        (xtal_hz),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .setup_kind     (setup_kind),
    .pll_mul        (pll_mul),
    .prescaler_code (prescaler_code),
    .master_hz      (master_hz)
  );

  clock_setup_search_core_checker checker_inst (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .target_hz      (target_hz),
    .xtal_hz        (xtal_hz),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .setup_kind     (setup_kind),
    .pll_mul        (pll_mul),
    .prescaler_code (prescaler_code),
    .master_hz      (master_hz),
    .errors         (errors),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(4, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic send_request(input logic [31:0] want, input logic [25:0] xtal);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else if ($urandom_range(49) == 0) begin
      calm_left = $urandom_range(40, 10);
      gap = 0;
    end else begin
      gap = pick_idle();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    target_hz <= want;
    xtal_hz   <= xtal;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [25:0] random_crystal();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 26'd0;
    if (r < 40) return 26'($urandom_range(1000, 1));
    if (r < 50) return 26'($urandom_range(MAX_CRYSTAL_HZ, 33554432));
    return 26'($urandom_range(MAX_CRYSTAL_HZ, 1));
  endfunction

  function automatic logic [31:0] random_desired(input logic [25:0] xtal);
    int r;
    r = $urandom_range(99);
    if (r < 6) begin
      case ($urandom_range(3))
        0: return css_pkg::RC4_HZ;
        1: return css_pkg::RC8_HZ;
        2: return css_pkg::RC12_HZ;
        default: return css_pkg::SLOW_CLOCK_HZ;
      endcase
    end
    if (r < 12 && xtal != 26'd0) return {6'd0, xtal};
    if (r < 15) return 32'd0;
    if (r < 22) return $urandom_range(32'hFFFF_FFFF, 32'd120000001);
    if (r < 34) return $urandom_range(100000, 1);
    if (r < 40) return $urandom_range(120000000, 119000000);
    return $urandom_range(120000000, 1);
  endfunction

  initial begin
    int run;
    out_stall <= 1'b0;
    forever begin
      if ($urandom_range(19) == 0) begin
        out_stall <= 1'b0;
        run = $urandom_range(600, 200);
      end else begin
        out_stall <= ($urandom_range(99) < 40);
        run = pick_idle() + 1;
      end
      repeat (run) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [25:0] xtal;
    int          spin;
    calm_left    = 0;
    drain_hung   = 1'b0;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    target_hz    <= '0;
    xtal_hz      <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_request(32'd0, 26'd0);
    send_request(32'd0, 26'd12000000);
    send_request(32'd120000000, 26'd0);
    send_request(32'd120000001, 26'd0);
    send_request(32'hFFFF_FFFF, 26'd50000000);
    send_request(css_pkg::RC4_HZ, 26'd16000000);
    send_request(css_pkg::RC8_HZ, 26'd0);
    send_request(css_pkg::RC12_HZ, 26'd12000000);
    send_request(css_pkg::SLOW_CLOCK_HZ, 26'd32768);
    send_request(32'd16000000, 26'd16000000);
    send_request(32'd50000000, 26'd50000000);
    send_request(32'd1, 26'd0);
    send_request(32'd1, 26'd50000000);
    send_request(32'd1, 26'd1);
    send_request(32'd100, 26'd1);
    send_request(32'd120000000, 26'd1);
    send_request(32'd119999999, 26'd50000000);
    send_request(32'd48000000, 26'd0);
    send_request(32'd33333333, 26'd3000000);
    send_request(32'd5, 26'd2);
    send_request(32'd7, 26'h2AA_AAAA);
    send_request(32'h0555_5555, 26'h155_5555);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      xtal = random_crystal();
      send_request(random_desired(xtal), xtal);
    end
    in_valid <= 1'b0;

    spin = 0;
    do begin
      @(posedge clk);
      spin++;
    end while (pending != 0 && spin < DRAIN_LIMIT);
    if (pending != 0) begin
      $error("%0d requests never answered", pending);
      drain_hung = 1'b1;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && !drain_hung) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: clock_setup_search_core.f
+incdir+hw/rtl
hw/rtl/css_pkg.sv
hw/rtl/clock_setup_search_core.sv
test/clock_setup_search_core_checker.sv
test/clock_setup_search_core_tb.sv
